// ----- rtl/lsq_pkg.sv -----
// Package for the load/store queue: operation and status codes, packed word layouts
// and the control structs passed between the queue and its entries.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lsq_pkg;

   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 5;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 2;
   localparam int SLOT_W     = 3;
   localparam int FIELD_TAG_W = 6;
   localparam int FIELD_ROB_W = 6;
   localparam int WORD_W     = 32;

   typedef enum logic [3:0] {
      FUNC_ALLOC    = 4'd0,
      FUNC_SET_ADDR = 4'd1,
      FUNC_SET_DATA = 4'd2,
      FUNC_COMPLETE = 4'd3,
      FUNC_RETIRE   = 4'd4,
      FUNC_SET_BTAG = 4'd5,
      FUNC_SET_OTAG = 4'd6,
      FUNC_SET_DTAG = 4'd7,
      FUNC_BCAST    = 4'd8,
      FUNC_QUERY    = 4'd9
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_RANGE   = 2'd2,
      STATUS_REFUSED = 2'd3
   } status_type;

   typedef struct packed {
      logic                   spare;
      logic [WORD_W-1:0]      word;
      logic [FIELD_TAG_W-1:0] reg_tag;
      logic [FIELD_ROB_W-1:0] rob_slot;
      logic [SLOT_W-1:0]      slot;
   } req_data_type;

   typedef struct packed {
      logic     store_flag;
      func_type func;
   } req_user_type;

   typedef struct packed {
      logic              spare;
      logic [2:0]        occupancy;
      logic              may_execute;
      logic [SLOT_W-1:0] alloc_slot;
   } rsp_data_type;

   typedef struct packed {
      logic alloc;
      logic clear;
      logic set_addr;
      logic write_data;
      logic set_done;
      logic set_btag;
      logic set_otag;
      logic set_dtag;
      logic bcast;
   } ent_cmd_type;

   typedef struct packed {
      logic store_op;
      logic addr_rdy;
      logic data_rdy;
      logic done;
   } ent_status_type;

endpackage

`default_nettype wire

// ----- rtl/load_store_queue.sv -----
// Top level of the in-order circular load/store queue.
// Depends on lsq_pkg and instantiates lsq_slot_unit once per queue slot.
`timescale 1ns / 1ps
`default_nettype none

// The queue takes one operation word per cycle while the result side keeps taking
// words, and returns exactly one result word for each, in order. A word passes an
// input register, is decoded and applied to the entries as it leaves that register,
// and its result is held in an output register. A broadcast compares its tag against
// every entry at once, and each entry has its own adder for base plus offset.
module load_store_queue #(
   parameter int QUEUE_DEPTH = 6,
   parameter int TAG_BITS    = 6,
   parameter int ROB_BITS    = 6
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // slot, rob_slot, reg_tag, word, zero pad
   input  wire logic [lsq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // func, store_flag
   input  wire logic [lsq_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // alloc_slot, may_execute, occupancy, zero pad
   output logic [lsq_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // status
   output logic [lsq_pkg::RSP_USER_W-1:0]       rsp_tuser
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                    in_valid_ff;
   lsq_pkg::req_data_type   in_data_ff;
   lsq_pkg::req_user_type   in_user_ff;
   logic                    out_valid_ff;
   lsq_pkg::rsp_data_type   out_data_ff, out_data_in;
   lsq_pkg::status_type     out_status_ff, out_status_in;
   logic [PTR_W-1:0]        head_ptr_ff, head_ptr_in;
   logic [PTR_W-1:0]        tail_ptr_ff, tail_ptr_in;
   logic [CNT_W-1:0]        fill_count_ff, fill_count_in;

   logic                    fire;
   logic                    in_range;
   logic [PTR_W-1:0]        slot_idx;
   logic [TAG_BITS-1:0]     bus_tag;
   logic [ROB_BITS-1:0]     alloc_rob;
   logic                    do_alloc, do_retire, do_bcast;
   logic                    do_addr, do_data, do_done, do_btag, do_otag, do_dtag;
   logic                    may_execute;

   lsq_pkg::ent_cmd_type    cmd [QUEUE_DEPTH];
   lsq_pkg::ent_status_type ent [QUEUE_DEPTH];

   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= lsq_pkg::req_data_type'(req_tdata);
         in_user_ff <= lsq_pkg::req_user_type'(req_tuser);
      end
   end

   assign in_range  = 32'(in_data_ff.slot) < QUEUE_DEPTH;
   assign slot_idx  = PTR_W'(in_data_ff.slot);
   assign bus_tag   = TAG_BITS'(in_data_ff.reg_tag);
   assign alloc_rob = ROB_BITS'(in_data_ff.rob_slot);

   always_comb begin
      out_status_in = lsq_pkg::STATUS_DONE;
      may_execute   = 1'b0;
      do_alloc      = 1'b0;
      do_retire     = 1'b0;
      do_bcast      = 1'b0;
      do_addr       = 1'b0;
      do_data       = 1'b0;
      do_done       = 1'b0;
      do_btag       = 1'b0;
      do_otag       = 1'b0;
      do_dtag       = 1'b0;
      head_ptr_in   = head_ptr_ff;
      tail_ptr_in   = tail_ptr_ff;
      fill_count_in = fill_count_ff;

      case (in_user_ff.func)
         lsq_pkg::FUNC_ALLOC: begin
            if (fill_count_ff == CNT_W'(QUEUE_DEPTH)) begin
               out_status_in = lsq_pkg::STATUS_FULL;
            end else begin
               do_alloc      = 1'b1;
               tail_ptr_in   = (tail_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                             : tail_ptr_ff + 1'b1;
               fill_count_in = fill_count_ff + 1'b1;
            end
         end
         lsq_pkg::FUNC_RETIRE: begin
            if (fill_count_ff == '0 || !ent[head_ptr_ff].done) begin
               out_status_in = lsq_pkg::STATUS_REFUSED;
            end else begin
               do_retire     = 1'b1;
               head_ptr_in   = (head_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                             : head_ptr_ff + 1'b1;
               fill_count_in = fill_count_ff - 1'b1;
            end
         end
         lsq_pkg::FUNC_BCAST: begin
            do_bcast = 1'b1;
         end
         lsq_pkg::FUNC_SET_ADDR, lsq_pkg::FUNC_SET_DATA, lsq_pkg::FUNC_COMPLETE,
         lsq_pkg::FUNC_SET_BTAG, lsq_pkg::FUNC_SET_OTAG, lsq_pkg::FUNC_SET_DTAG,
         lsq_pkg::FUNC_QUERY: begin
            if (!in_range) begin
               out_status_in = lsq_pkg::STATUS_RANGE;
            end else begin
               do_addr = in_user_ff.func == lsq_pkg::FUNC_SET_ADDR;
               do_data = in_user_ff.func == lsq_pkg::FUNC_SET_DATA;
               do_done = in_user_ff.func == lsq_pkg::FUNC_COMPLETE;
               do_btag = in_user_ff.func == lsq_pkg::FUNC_SET_BTAG;
               do_otag = in_user_ff.func == lsq_pkg::FUNC_SET_OTAG;
               do_dtag = in_user_ff.func == lsq_pkg::FUNC_SET_DTAG;
               if (in_user_ff.func == lsq_pkg::FUNC_QUERY) begin
                  may_execute = (slot_idx == head_ptr_ff) && ent[slot_idx].addr_rdy &&
                                (!ent[slot_idx].store_op || ent[slot_idx].data_rdy);
               end
            end
         end
         default: begin
         end
      endcase

      out_data_in.spare       = 1'b0;
      out_data_in.occupancy   = 3'(fill_count_in);
      out_data_in.may_execute = may_execute;
      out_data_in.alloc_slot  = do_alloc ? lsq_pkg::SLOT_W'(tail_ptr_ff) : '0;
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_entry
      logic at_slot, at_head, at_tail;

      assign at_slot = fire && (slot_idx == PTR_W'(i));
      assign at_head = fire && (head_ptr_ff == PTR_W'(i));
      assign at_tail = fire && (tail_ptr_ff == PTR_W'(i));

      assign cmd[i].alloc      = do_alloc && at_tail;
      assign cmd[i].clear      = do_retire && at_head;
      assign cmd[i].set_addr   = do_addr && at_slot;
      assign cmd[i].write_data = do_data && at_slot;
      assign cmd[i].set_done   = do_done && at_slot;
      assign cmd[i].set_btag   = do_btag && at_slot;
      assign cmd[i].set_otag   = do_otag && at_slot;
      assign cmd[i].set_dtag   = do_dtag && at_slot;
      assign cmd[i].bcast      = do_bcast && fire;

      lsq_slot_unit #(
         .TAG_BITS(TAG_BITS),
         .ROB_BITS(ROB_BITS)
      ) u_entry (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd[i]),
         .alloc_store(in_user_ff.store_flag),
         .alloc_rob  (alloc_rob),
         .bus_tag    (bus_tag),
         .bus_word   (in_data_ff.word),
         .status     (ent[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ptr_ff   <= '0;
         tail_ptr_ff   <= '0;
         fill_count_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (fire) begin
            head_ptr_ff   <= head_ptr_in;
            tail_ptr_ff   <= tail_ptr_in;
            fill_count_ff <= fill_count_in;
            out_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff   <= out_data_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

`default_nettype wire

// ----- rtl/lsq_entry.sv -----
// One load/store queue entry: operand tags, ready flags, values and the address adder.
// Depends on lsq_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module lsq_slot_unit #(
   parameter int TAG_BITS = 6,
   parameter int ROB_BITS = 6
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lsq_pkg::ent_cmd_type        cmd,
   input  wire logic                        alloc_store,
   input  wire logic [ROB_BITS-1:0]         alloc_rob,
   input  wire logic [TAG_BITS-1:0]         bus_tag,
   input  wire logic [lsq_pkg::WORD_W-1:0]  bus_word,
   output lsq_pkg::ent_status_type          status
);

   logic                       store_op_ff, store_op_in;
   logic [ROB_BITS-1:0]        rob_ff, rob_in;
   logic [lsq_pkg::WORD_W-1:0] addr_ff, addr_in;
   logic                       addr_rdy_ff, addr_rdy_in;
   logic [lsq_pkg::WORD_W-1:0] data_ff, data_in;
   logic                       data_rdy_ff, data_rdy_in;
   logic [TAG_BITS-1:0]        btag_ff, btag_in;
   logic [TAG_BITS-1:0]        otag_ff, otag_in;
   logic [TAG_BITS-1:0]        dtag_ff, dtag_in;
   logic [lsq_pkg::WORD_W-1:0] bval_ff, bval_in;
   logic                       b_rdy_ff, b_rdy_in;
   logic [lsq_pkg::WORD_W-1:0] oval_ff, oval_in;
   logic                       o_rdy_ff, o_rdy_in;
   logic                       done_ff, done_in;
   logic                       b_hit, o_hit, d_hit;

   assign b_hit = !b_rdy_ff && (btag_ff == bus_tag);
   assign o_hit = !o_rdy_ff && (otag_ff == bus_tag);
   assign d_hit = store_op_ff && !data_rdy_ff && (dtag_ff == bus_tag);

   always_comb begin
      store_op_in = store_op_ff;
      rob_in      = rob_ff;
      addr_in     = addr_ff;
      addr_rdy_in = addr_rdy_ff;
      data_in     = data_ff;
      data_rdy_in = data_rdy_ff;
      btag_in     = btag_ff;
      otag_in     = otag_ff;
      dtag_in     = dtag_ff;
      bval_in     = bval_ff;
      b_rdy_in    = b_rdy_ff;
      oval_in     = oval_ff;
      o_rdy_in    = o_rdy_ff;
      done_in     = done_ff;

      if (cmd.alloc || cmd.clear) begin
         store_op_in = cmd.alloc && alloc_store;
         rob_in      = cmd.alloc ? alloc_rob : '0;
         addr_in     = '0;
         addr_rdy_in = 1'b0;
         data_in     = '0;
         data_rdy_in = 1'b0;
         btag_in     = '0;
         otag_in     = '0;
         dtag_in     = '0;
         bval_in     = '0;
         b_rdy_in    = 1'b0;
         oval_in     = '0;
         o_rdy_in    = 1'b0;
         done_in     = 1'b0;
      end
      if (cmd.set_addr) begin
         addr_in     = bus_word;
         addr_rdy_in = 1'b1;
      end
      if (cmd.write_data) begin
         data_in     = bus_word;
         data_rdy_in = 1'b1;
      end
      if (cmd.set_done) begin
         done_in = 1'b1;
      end
      if (cmd.set_btag) begin
         btag_in = bus_tag;
      end
      if (cmd.set_otag) begin
         otag_in = bus_tag;
      end
      if (cmd.set_dtag) begin
         dtag_in = bus_tag;
      end
      if (cmd.bcast) begin
         if (b_hit) begin
            bval_in  = bus_word;
            b_rdy_in = 1'b1;
         end
         if (o_hit) begin
            oval_in  = bus_word;
            o_rdy_in = 1'b1;
         end
         if (d_hit) begin
            data_in     = bus_word;
            data_rdy_in = 1'b1;
         end
         // The address is formed once, as soon as both operands are present.
         if (!addr_rdy_ff && b_rdy_in && o_rdy_in) begin
            addr_in     = bval_in + oval_in;
            addr_rdy_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_op_ff <= 1'b0;
         addr_rdy_ff <= 1'b0;
         data_rdy_ff <= 1'b0;
         btag_ff     <= '0;
         otag_ff     <= '0;
         dtag_ff     <= '0;
         b_rdy_ff    <= 1'b0;
         o_rdy_ff    <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         store_op_ff <= store_op_in;
         addr_rdy_ff <= addr_rdy_in;
         data_rdy_ff <= data_rdy_in;
         btag_ff     <= btag_in;
         otag_ff     <= otag_in;
         dtag_ff     <= dtag_in;
         b_rdy_ff    <= b_rdy_in;
         o_rdy_ff    <= o_rdy_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rob_ff  <= rob_in;
      addr_ff <= addr_in;
      data_ff <= data_in;
      bval_ff <= bval_in;
      oval_ff <= oval_in;
   end

   assign status.store_op = store_op_ff;
   assign status.addr_rdy = addr_rdy_ff;
   assign status.data_rdy = data_rdy_ff;
   assign status.done     = done_ff;

endmodule

`default_nettype wire

// ----- rtl/lsq_checker.sv -----
// Port-level checker for load_store_queue and the bind that attaches it.
// Depends on lsq_pkg for the status codes and result word layout.
`timescale 1ns / 1ps
`default_nettype none

module lsq_checker #(
   parameter int QUEUE_DEPTH = 6
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [lsq_pkg::REQ_DATA_W-1:0]  req_tdata,
   input wire logic [lsq_pkg::REQ_USER_W-1:0]  req_tuser,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [lsq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [lsq_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   lsq_pkg::rsp_data_type rsp;

   assign rsp = lsq_pkg::rsp_data_type'(rsp_tdata);

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word presented right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == lsq_pkg::STATUS_FULL |-> rsp.occupancy == 3'(QUEUE_DEPTH))
      else $error("queue full reported with spare entries");

   a_grant_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.may_execute || rsp.alloc_slot != '0)
         |-> rsp_tuser == lsq_pkg::STATUS_DONE)
      else $error("slot grant or execute flag with a failing status");

endmodule

bind load_store_queue lsq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_lsq_checker (.*);

`default_nettype wire
